// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the decimal string parser RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain invariant, sampled on every rising edge outside reset.
`define DSP_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Same-cycle implication.
`define DSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define DSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSP_ASSERT(lbl, clk, rst_n, expr, msg)
`define DSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/dsp_pkg.sv -----
// Types and constants for the decimal string parser.
// No dependencies; used by dsp_step and the top level.
package dsp_pkg;

  localparam int CHAR_W = 8;
  localparam int FRAC_W = 6;
  localparam int EXP_W  = 32;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LO_E  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [FRAC_W-1:0] FRAC_SAT = '1;
  localparam logic [EXP_W-1:0]  EXP_SAT  = '1;
  localparam logic [EXP_W-1:0]  EXP_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [EXP_W-1:0]  EXP_NEG_MAX = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_WHOLE      = 3'd1,
    PH_FRAC       = 3'd2,
    PH_EXP_START  = 3'd3,
    PH_EXP_SIGN   = 3'd4,
    PH_EXP_DIGITS = 3'd5,
    PH_FAILED     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_NO_DIGITS    = 3'd2,
    ST_SIGN_ONLY    = 3'd3,
    ST_BAD_EXP_CHAR = 3'd4,
    ST_JUNK         = 3'd5,
    ST_TOO_LARGE    = 3'd6,
    ST_EXP_INVALID  = 3'd7
  } status_t;

  // Parser control state, everything but the value magnitude.
  typedef struct packed {
    phase_t            phase;
    logic              neg_seen;
    logic              whole_seen;
    logic [FRAC_W-1:0] frac_count;
    logic [EXP_W-1:0]  exp_mag;
    logic              exp_neg;
    status_t           err;
    logic              value_over;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase:      PH_START,
    neg_seen:   1'b0,
    whole_seen: 1'b0,
    frac_count: '0,
    exp_mag:    '0,
    exp_neg:    1'b0,
    err:        ST_OK,
    value_over: 1'b0
  };

  // One result word, less the magnitude.
  typedef struct packed {
    status_t           status;
    logic              is_negative;
    logic [FRAC_W-1:0] fraction_digits;
    logic [EXP_W-1:0]  exponent;
  } res_t;

endpackage

// ----- rtl/dsp_mac10.sv -----
// Times-ten plus digit for the value magnitude, with range check.
// Depends on nothing but its MAG_W parameter.
module dsp_mac10 #(
  parameter int MAG_W = 127
) (
  input  logic [MAG_W-1:0] mag,
  input  logic [3:0]       digit,
  output logic [MAG_W-1:0] mag_nxt,
  output logic             over
);

  localparam int WIDE_W = MAG_W + 4;

  logic [WIDE_W-1:0] mag_ext;
  logic [WIDE_W-1:0] wide;

  assign mag_ext = WIDE_W'(mag);
  // x*10 = x*8 + x*2
  assign wide    = (mag_ext << 3) + (mag_ext << 1) + WIDE_W'(digit);
  assign mag_nxt = wide[MAG_W-1:0];
  assign over    = |wide[WIDE_W-1:MAG_W];

endmodule

// ----- rtl/dsp_step.sv -----
// Per-character next-state and result logic of the parser.
// Depends on dsp_pkg and dsp_mac10.
module dsp_step #(
  parameter int MAG_W        = 127,
  parameter int MAX_FRACTION = 38
) (
  input  dsp_pkg::ctl_t                 cur,
  input  logic [MAG_W-1:0]              cur_mag,
  input  logic [dsp_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  input  logic                          empty_string,
  output dsp_pkg::ctl_t                 nxt,
  output logic [MAG_W-1:0]              nxt_mag,
  output dsp_pkg::res_t                 res,
  output logic [MAG_W-1:0]              res_mag
);

  localparam logic [dsp_pkg::FRAC_W-1:0] FRAC_LIMIT = dsp_pkg::FRAC_W'(MAX_FRACTION);

  dsp_pkg::ctl_t                 aft;
  logic [MAG_W-1:0]              aft_mag;
  logic [MAG_W-1:0]              mac_mag;
  logic                          mac_over;
  logic                          dig;
  logic                          is_e;
  logic                          do_val;
  logic                          do_exp;
  logic [3:0]                    digit;
  logic [dsp_pkg::EXP_W+3:0]     exp_wide;
  logic [dsp_pkg::EXP_W-1:0]     exp_new;
  logic [dsp_pkg::FRAC_W-1:0]    frac_inc;
  dsp_pkg::status_t              fin;
  logic                          ok;

  assign dig   = (char_code >= dsp_pkg::CH_ZERO) && (char_code <= dsp_pkg::CH_NINE);
  assign is_e  = (char_code == dsp_pkg::CH_LO_E) || (char_code == dsp_pkg::CH_UP_E);
  assign digit = char_code[3:0];

  dsp_mac10 #(.MAG_W(MAG_W)) u_mac10 (
    .mag     (cur_mag),
    .digit   (digit),
    .mag_nxt (mac_mag),
    .over    (mac_over)
  );

  // Exponent accumulate, saturating to all ones once past 2^31
  assign exp_wide = ((dsp_pkg::EXP_W+4)'(cur.exp_mag) << 3)
                  + ((dsp_pkg::EXP_W+4)'(cur.exp_mag) << 1)
                  + (dsp_pkg::EXP_W+4)'(digit);
  assign exp_new  = ((cur.exp_mag == dsp_pkg::EXP_SAT) ||
                     (exp_wide > (dsp_pkg::EXP_W+4)'(dsp_pkg::EXP_NEG_MAX)))
                    ? dsp_pkg::EXP_SAT : exp_wide[dsp_pkg::EXP_W-1:0];

  assign frac_inc = (cur.frac_count == dsp_pkg::FRAC_SAT) ? cur.frac_count
                    : cur.frac_count + dsp_pkg::FRAC_W'(1);

  always_comb begin
    aft     = cur;
    aft_mag = cur_mag;
    do_val  = 1'b0;
    do_exp  = 1'b0;
    if ((cur.phase == dsp_pkg::PH_START) &&
        ((char_code == dsp_pkg::CH_MINUS) || (char_code == dsp_pkg::CH_PLUS))) begin
      aft.neg_seen = (char_code == dsp_pkg::CH_MINUS);
      aft.phase    = dsp_pkg::PH_WHOLE;
    end else begin
      unique case (cur.phase)
        dsp_pkg::PH_START, dsp_pkg::PH_WHOLE: begin
          aft.phase = dsp_pkg::PH_WHOLE;
          if (dig) begin
            do_val         = 1'b1;
            aft.whole_seen = 1'b1;
          end else if (char_code == dsp_pkg::CH_DOT) begin
            aft.phase = dsp_pkg::PH_FRAC;
          end else if (!cur.whole_seen) begin
            aft.phase = dsp_pkg::PH_FAILED;
            aft.err   = dsp_pkg::ST_NO_DIGITS;
          end else if (is_e) begin
            aft.phase = dsp_pkg::PH_EXP_START;
          end else begin
            aft.phase = dsp_pkg::PH_FAILED;
            aft.err   = dsp_pkg::ST_JUNK;
          end
        end
        dsp_pkg::PH_FRAC: begin
          if (dig) begin
            do_val         = 1'b1;
            aft.frac_count = frac_inc;
            if (frac_inc > FRAC_LIMIT) aft.value_over = 1'b1;
          end else if (!cur.whole_seen && (cur.frac_count == '0)) begin
            aft.phase = dsp_pkg::PH_FAILED;
            aft.err   = dsp_pkg::ST_NO_DIGITS;
          end else if (is_e) begin
            aft.phase = dsp_pkg::PH_EXP_START;
          end else begin
            aft.phase = dsp_pkg::PH_FAILED;
            aft.err   = dsp_pkg::ST_JUNK;
          end
        end
        dsp_pkg::PH_EXP_START: begin
          if ((char_code == dsp_pkg::CH_MINUS) || (char_code == dsp_pkg::CH_PLUS)) begin
            if (last_char) begin
              aft.phase = dsp_pkg::PH_FAILED;
              aft.err   = dsp_pkg::ST_SIGN_ONLY;
            end else begin
              aft.exp_neg = (char_code == dsp_pkg::CH_MINUS);
              aft.phase   = dsp_pkg::PH_EXP_SIGN;
            end
          end else if (dig) begin
            do_exp = 1'b1;
          end else begin
            aft.phase = dsp_pkg::PH_FAILED;
            aft.err   = dsp_pkg::ST_BAD_EXP_CHAR;
          end
        end
        dsp_pkg::PH_EXP_SIGN, dsp_pkg::PH_EXP_DIGITS: begin
          if (dig) begin
            do_exp = 1'b1;
          end else begin
            aft.phase = dsp_pkg::PH_FAILED;
            aft.err   = dsp_pkg::ST_BAD_EXP_CHAR;
          end
        end
        default: begin
        end
      endcase
    end
    // value digit: sticky overflow freezes the magnitude
    if (do_val && !cur.value_over) begin
      if (mac_over) aft.value_over = 1'b1;
      else          aft_mag        = mac_mag;
    end
    if (do_exp) begin
      aft.exp_mag = exp_new;
      aft.phase   = dsp_pkg::PH_EXP_DIGITS;
    end
  end

  // End-of-string status; character errors first, then missing digits or exponent faults, then size
  always_comb begin
    fin = dsp_pkg::ST_OK;
    if (aft.err != dsp_pkg::ST_OK) begin
      fin = aft.err;
    end else begin
      unique case (aft.phase)
        dsp_pkg::PH_START, dsp_pkg::PH_WHOLE: begin
          if (!aft.whole_seen) fin = dsp_pkg::ST_NO_DIGITS;
        end
        dsp_pkg::PH_FRAC: begin
          if (!aft.whole_seen && (aft.frac_count == '0)) fin = dsp_pkg::ST_NO_DIGITS;
        end
        dsp_pkg::PH_EXP_START: fin = dsp_pkg::ST_EXP_INVALID;
        dsp_pkg::PH_EXP_SIGN:  fin = dsp_pkg::ST_SIGN_ONLY;
        dsp_pkg::PH_EXP_DIGITS: begin
          if (aft.exp_mag > (aft.exp_neg ? dsp_pkg::EXP_NEG_MAX : dsp_pkg::EXP_POS_MAX))
            fin = dsp_pkg::ST_EXP_INVALID;
        end
        default: begin
        end
      endcase
      if ((fin == dsp_pkg::ST_OK) && aft.value_over) fin = dsp_pkg::ST_TOO_LARGE;
    end
  end

  always_comb begin
    res.status          = empty_string ? dsp_pkg::ST_EMPTY : fin;
    ok                  = (res.status == dsp_pkg::ST_OK);
    res.is_negative     = ok & aft.neg_seen;
    res.fraction_digits = ok ? aft.frac_count : '0;
    res.exponent        = !ok ? '0
                        : (aft.exp_neg ? (~aft.exp_mag + dsp_pkg::EXP_W'(1)) : aft.exp_mag);
    res_mag             = ok ? aft_mag : '0;
  end

  // A string end or an empty string returns the parser to its reset state
  always_comb begin
    if (empty_string || last_char) begin
      nxt     = dsp_pkg::CTL_RESET;
      nxt_mag = '0;
    end else begin
      nxt     = aft;
      nxt_mag = aft_mag;
    end
  end

endmodule

// ----- rtl/decimal_string_parser_core.sv -----
// Decimal string parser: up to one character word per cycle, one result word per string.
// Input accept reaches out_valid through the input register, then the result register.
// Throughput: 1 char per cycle unless out_ready stalls; step is a single times-ten add.
// Reset (rst_n low, synchronous): parser back to start of string, both registers empty.
// Depends on dsp_pkg, dsp_step, dsp_mac10 and assert_macros.svh.
`include "assert_macros.svh"
module decimal_string_parser_core #(
  parameter int VALUE_BITS   = 128,
  parameter int MAX_FRACTION = 38
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // character words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dsp_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_last_char,
  input  logic                       in_empty_string,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic                       out_is_negative,
  output logic [63:0]                out_value_low,
  output logic [62:0]                out_value_high,
  output logic [dsp_pkg::FRAC_W-1:0] out_fraction_digits,
  output logic signed [31:0]         out_exponent
);

  // The magnitude must fit a signed VALUE_BITS value, so one bit less is kept.
  localparam int MAG_W = VALUE_BITS - 1;
  localparam int OUT_W = 127;

  // ---- input register ----
  logic                       in_vld_r;
  logic [dsp_pkg::CHAR_W-1:0] char_r;
  logic                       last_r;
  logic                       empty_r;

  // ---- parser state ----
  dsp_pkg::ctl_t              ctl_r, ctl_nxt;
  logic [MAG_W-1:0]           mag_r, mag_nxt;

  // ---- result register ----
  logic                       out_vld_r;
  dsp_pkg::res_t              res_r;
  logic [MAG_W-1:0]           res_mag_r;

  dsp_pkg::res_t              res;
  logic [MAG_W-1:0]           res_mag;
  logic                       res_vld;
  logic                       out_free;
  logic                       advance;
  logic [OUT_W-1:0]           mag_ext;

  // The held word moves on when it makes no result, or the result slot is
  // free or draining this cycle.
  assign res_vld  = empty_r | last_r;
  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && (!res_vld || out_free);
  assign in_ready = !in_vld_r || advance;

  dsp_step #(
    .MAG_W        (MAG_W),
    .MAX_FRACTION (MAX_FRACTION)
  ) u_step (
    .cur          (ctl_r),
    .cur_mag      (mag_r),
    .char_code    (char_r),
    .last_char    (last_r),
    .empty_string (empty_r),
    .nxt          (ctl_nxt),
    .nxt_mag      (mag_nxt),
    .res          (res),
    .res_mag      (res_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r  <= in_char_code;
      last_r  <= in_last_char;
      empty_r <= in_empty_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= dsp_pkg::CTL_RESET;
      mag_r <= '0;
    end else if (advance) begin
      ctl_r <= ctl_nxt;
      mag_r <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r     <= res;
      res_mag_r <= res_mag;
    end
  end

  // Magnitude zero-extended to the fixed 127-bit result split
  assign mag_ext = OUT_W'(res_mag_r);

  assign out_valid           = out_vld_r;
  assign out_status          = res_r.status;
  assign out_is_negative     = res_r.is_negative;
  assign out_value_low       = mag_ext[63:0];
  assign out_value_high      = mag_ext[126:64];
  assign out_fraction_digits = res_r.fraction_digits;
  assign out_exponent        = signed'(res_r.exponent);

  // ---- checks ----
  `DSP_ASSERT_IMP(a_err_fields_zero, clk, rst_n,
    out_vld_r && (res_r.status != dsp_pkg::ST_OK),
    (res_mag_r == '0) && !res_r.is_negative && (res_r.exponent == '0),
    "error result carries non-zero fields")
  `DSP_ASSERT_IMP(a_frac_in_range, clk, rst_n,
    out_vld_r && (res_r.status == dsp_pkg::ST_OK),
    res_r.fraction_digits <= dsp_pkg::FRAC_W'(MAX_FRACTION),
    "fraction count beyond limit in ok result")
  `DSP_ASSERT_NXT(a_restart_after_end, clk, rst_n,
    advance && res_vld,
    (ctl_r.phase == dsp_pkg::PH_START) && (ctl_r.err == dsp_pkg::ST_OK) && (mag_r == '0),
    "parser not back at start after string end")
  `DSP_ASSERT_NXT(a_hold_stalled_word, clk, rst_n,
    in_vld_r && !advance,
    in_vld_r,
    "stalled input word lost")

endmodule
